>>> hdl/twdd_pkg.sv
// Package for the tile word delta decoder: sizes, register and format codes,
// and the record passed from the byte stage to the word stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twdd_pkg;

   // Depth of the high byte plane store, in words.
   localparam int MaxWords = 4096;
   localparam int AddrW    = $clog2(MaxWords);

   localparam int LenW   = 14;
   localparam int FmtW   = 8;
   localparam int PosW   = 14;
   localparam int CountW = 13;
   localparam int ByteW  = 8;
   localparam int WordW  = 16;

   localparam int CountCapInt = (MaxWords > 8191) ? 8191 : MaxWords;
   localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);

   // Register indexes on the csr port.
   localparam logic RegBlockLength = 1'b0;
   localparam logic RegFormat      = 1'b1;

   // Format codes.
   localparam logic [FmtW-1:0] FmtRaw   = 8'd0;
   localparam logic [FmtW-1:0] FmtSplit = 8'd1;
   localparam logic [FmtW-1:0] FmtXor   = 8'd2;

   typedef struct packed {
      logic             emit;
      logic             xor_en;
      logic             split;
      logic             last;
      logic [WordW-1:0] raw;
   } stage_type;

endpackage

`default_nettype wire

>>> hdl/twdd_plane_ram.sv
// Single port-pair synchronous RAM holding the high byte plane of format 1.
// Depends on twdd_pkg for depth and widths.
`timescale 1ns / 1ps
`default_nettype none

module twdd_plane_ram import twdd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [ByteW-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [ByteW-1:0] rd_data
);

   logic [ByteW-1:0] mem_ff [MaxWords];
   logic [ByteW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/twdd_byte_stage.sv
// Byte stage: tracks the position in the block, pairs bytes, drives the plane
// RAM and holds one decoded item for the word stage. Depends on twdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twdd_byte_stage import twdd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [LenW-1:0]  block_length,
   input  wire logic [FmtW-1:0]  format,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [ByteW-1:0] req_payload_byte,
   input  wire logic             out_free,
   output logic                  load,
   output stage_type             item,
   output logic                  restart,
   output logic                  ram_wr_en,
   output logic [AddrW-1:0]      ram_wr_addr,
   output logic [ByteW-1:0]      ram_wr_data,
   output logic                  ram_rd_en,
   output logic [AddrW-1:0]      ram_rd_addr
);

   logic [PosW-1:0]   pos_ff, pos_in;
   logic [ByteW-1:0]  pending_ff, pending_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;

   logic [LenW-1:0]   len_m1;
   logic [CountW-1:0] half;
   logic [CountW-1:0] count;
   logic [PosW-1:0]   total;
   logic [PosW-1:0]   pos;
   logic [PosW-1:0]   pos_inc;
   logic [PosW-1:0]   rd_off;
   logic              acc, active, odd, pairing, split, in_high, s1_go;

   always_comb begin
      len_m1  = block_length - LenW'(1);
      half    = (block_length == '0) ? '0 : len_m1[LenW-1:1];
      count   = (half > CountCap) ? CountCap : half;
      total   = {count, 1'b0};
      pos     = (pos_ff >= total) ? '0 : pos_ff;
      pos_inc = pos + PosW'(1);
      active  = (total != '0);
      odd     = block_length[0];
      pairing = (format == FmtRaw) || (format == FmtXor);
      split   = (format == FmtSplit);
      in_high = (pos < {1'b0, count});
      rd_off  = pos - {1'b0, count};

      s1_go     = s1_valid_ff && (!s1_ff.emit || out_free);
      req_ready = !s1_valid_ff || s1_go;
      acc       = req_valid && req_ready;

      // Plane writes land at least one word before the matching read.
      ram_wr_en   = acc && active && odd && split && in_high;
      ram_wr_addr = pos[AddrW-1:0];
      ram_wr_data = req_payload_byte;
      ram_rd_en   = acc;
      ram_rd_addr = rd_off[AddrW-1:0];

      restart = acc && active && (pos == '0);

      s1_in.emit   = active && odd && ((pairing && pos[0]) || (split && !in_high));
      s1_in.xor_en = (format != FmtRaw);
      s1_in.split  = split;
      s1_in.last   = (pos == total - PosW'(1));
      s1_in.raw    = split ? {8'h00, req_payload_byte} : {req_payload_byte, pending_ff};

      pending_in = pending_ff;
      if (acc && active && odd && pairing && !pos[0]) begin
         pending_in = req_payload_byte;
      end

      pos_in = pos_ff;
      if (acc) begin
         if (!active || pos_inc >= total) begin
            pos_in = '0;
         end else begin
            pos_in = pos_inc;
         end
      end

      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      load = s1_go && s1_ff.emit;
      item = s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         pending_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         pending_ff  <= pending_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ff <= s1_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/twdd_word_stage.sv
// Word stage: joins the stored high byte, applies the xor chain and holds the
// output word register. Depends on twdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twdd_word_stage import twdd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire stage_type        item,
   input  wire logic [ByteW-1:0] high_byte,
   input  wire logic             restart,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [WordW-1:0]      rsp_word,
   output logic                  rsp_last
);

   logic [WordW-1:0] prev_ff, prev_in;
   logic [WordW-1:0] word_ff;
   logic             last_ff;
   logic             valid_ff, valid_in;
   logic [WordW-1:0] joined, w;

   always_comb begin
      joined = {item.split ? high_byte : item.raw[15:8], item.raw[7:0]};
      w      = joined ^ (item.xor_en ? prev_ff : '0);

      // A new block clears the chain even while the last word of the old one
      // is being registered.
      if (restart) begin
         prev_in = '0;
      end else if (load) begin
         prev_in = w;
      end else begin
         prev_in = prev_ff;
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      out_free = !valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= w;
         last_ff <= item.last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;
   assign rsp_last  = last_ff;

endmodule

`default_nettype wire

>>> hdl/tile_word_delta_decoder_unit.sv
// Top level of the tile word delta decoder: configuration registers, byte
// stage, plane RAM and word stage. Depends on twdd_pkg and the twdd_* modules.
//
//   port group   direction  handshake            payload
//   req_*        in         req_valid/req_ready  req_payload_byte[7:0]
//   rsp_*        out        rsp_valid/rsp_ready  rsp_word[15:0], rsp_last
//   csr_*        in         csr_we               csr_index, csr_wdata[13:0]
//
// One byte is taken per cycle unless the rsp side stalls intake. A word is held
// in the byte stage, beside the registered read of the plane RAM, and then in
// the output register. Reset clears position, pending byte, xor chain and
// valid bits; the plane RAM needs no clearing. A stalled rsp side stops intake
// only once a word waits both in the byte stage and in the output register.
`timescale 1ns / 1ps
`default_nettype none

module tile_word_delta_decoder_unit import twdd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [LenW-1:0]  csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [ByteW-1:0] req_payload_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [WordW-1:0]      rsp_word,
   output logic                  rsp_last
);

   logic [LenW-1:0]  block_length_ff, block_length_in;
   logic [FmtW-1:0]  format_ff, format_in;

   logic             out_free, load, restart;
   stage_type        item;
   logic             ram_wr_en, ram_rd_en;
   logic [AddrW-1:0] ram_wr_addr, ram_rd_addr;
   logic [ByteW-1:0] ram_wr_data, ram_rd_data;

   always_comb begin
      block_length_in = block_length_ff;
      format_in       = format_ff;
      if (csr_we) begin
         case (csr_index)
            RegBlockLength: block_length_in = csr_wdata;
            RegFormat:      format_in       = csr_wdata[FmtW-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= '0;
         format_ff       <= '0;
      end else begin
         block_length_ff <= block_length_in;
         format_ff       <= format_in;
      end
   end

   twdd_byte_stage u_byte (
      .clock            (clock),
      .reset            (reset),
      .block_length     (block_length_ff),
      .format           (format_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .out_free         (out_free),
      .load             (load),
      .item             (item),
      .restart          (restart),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr)
   );

   twdd_plane_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   twdd_word_stage u_word (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .item      (item),
      .high_byte (ram_rd_data),
      .restart   (restart),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

endmodule

`default_nettype wire
